// ===== hdl/assert_macros.svh =====
// assertion macros shared by the console engine modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tcce_pkg.sv =====
// shared types, constants and helper functions of the text console engine
// used by tcce_front, tcce_back and text_console_cell_engine
`default_nettype none

package tcce_pkg;

    // default store geometry
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 96;

    // width of a computed cell address before the range check
    localparam int ADDR_W = 18;

    localparam logic [7:0]  BLANK_CHAR    = 8'h20;
    localparam logic [15:0] COLOR_RESET   = 16'hff04;
    localparam logic [7:0]  WIDTH_RESET   = 8'd128;
    localparam logic [6:0]  HEIGHT_RESET  = 7'd96;
    localparam logic [7:0]  PITCH_RESET   = 8'd128;
    localparam logic [7:0]  MAX_REGION_W  = 8'd128;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_REGION_COL    = 3'd0,
        REG_REGION_ROW    = 3'd1,
        REG_REGION_WIDTH  = 3'd2,
        REG_REGION_HEIGHT = 3'd3,
        REG_ROW_PITCH     = 3'd4,
        REG_TEXT_COLOR    = 3'd5
    } reg_idx_t;

    // classified command kinds
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_SET_POS,
        CMD_SCROLL,
        CMD_FILL,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT_ADDR,
        ST_PUT_WR,
        ST_SET_POS,
        ST_SCR_SETUP,
        ST_PHASE,
        ST_LOOP_ADDR,
        ST_LOOP_RD,
        ST_LOOP_WR,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_DONE
    } back_state_t;

    // region walk phases
    typedef enum logic [1:0] {
        PH_COPY,
        PH_BLANK_H,
        PH_BLANK_V,
        PH_FILL
    } phase_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  chr;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  shift_cols;
        logic [7:0]  shift_rows;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  region_col;
        logic [6:0]  region_row;
        logic [7:0]  region_width;
        logic [6:0]  region_height;
        logic [7:0]  row_pitch;
        logic [15:0] text_color;
    } cfg_t;

    // last member lands in the lowest bits
    typedef struct packed {
        logic [15:0] read_color;
        logic [7:0]  read_char;
        logic [7:0]  cursor_abs_row;
        logic [7:0]  cursor_abs_col;
        logic [6:0]  cursor_row;
        logic [6:0]  cursor_col;
    } result_t;

    typedef struct packed {
        logic [6:0]        col;
        logic [6:0]        row;
        logic              scroll;
        logic signed [9:0] vt;
    } pos_t;

    // region width as used: zero acts as one, capped at the cursor range
    function automatic logic [7:0] eff_width(input logic [7:0] w);
        logic [7:0] r;
        r = w;
        if (w == 8'd0) r = 8'd1;
        else if (w > MAX_REGION_W) r = MAX_REGION_W;
        return r;
    endfunction

    function automatic logic [7:0] eff_height(input logic [6:0] h);
        return (h == 7'd0) ? 8'd1 : {1'b0, h};
    endfunction

    // clamp a cursor request, wrap the column and report any scroll needed
    function automatic pos_t place_cursor(input logic signed [9:0] x,
                                          input logic signed [9:0] y,
                                          input logic [7:0] w,
                                          input logic [7:0] h);
        logic signed [9:0] xs;
        logic signed [9:0] ys;
        logic signed [9:0] wn;
        logic signed [9:0] hn;
        pos_t p;
        xs = x;
        ys = y;
        wn = $signed({2'b00, w});
        hn = $signed({2'b00, h});
        p.scroll = 1'b0;
        p.vt = '0;
        if (xs < 0) begin
            xs = '0;
        end else if (xs >= wn) begin
            xs = '0;
            ys = ys + 10'sd1;
        end
        if (ys < 0) begin
            ys = '0;
        end else if (ys >= hn) begin
            p.scroll = 1'b1;
            p.vt = ys - hn + 10'sd1;
            ys = hn - 10'sd1;
        end
        p.col = xs[6:0];
        p.row = ys[6:0];
        return p;
    endfunction

    // store address of a cell: row * pitch + column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [8:0] col,
                                                    input logic [8:0] row,
                                                    input logic [7:0] pitch);
        logic [16:0] prod;
        prod = {8'b0, row} * {9'b0, pitch};
        return {1'b0, prod} + {9'b0, col};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tcce_front.sv =====
// front end: accepts stream items, classifies the request and queues commands
// depends on tcce_pkg
`default_nettype none

module tcce_front
    import tcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        enable,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  in_type,
    input  logic [39:0] in_data,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    // request codes on the wire
    localparam logic [2:0] REQ_PUT     = 3'd0;
    localparam logic [2:0] REQ_SET_POS = 3'd1;
    localparam logic [2:0] REQ_SCROLL  = 3'd2;
    localparam logic [2:0] REQ_FILL    = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;
    localparam int QDEPTH = 2;

    cmd_t       q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       in_cmd;
    logic       push;
    logic       pop;

    // classify the incoming item
    always_comb
    begin
        in_cmd.chr        = in_data[7:0];
        in_cmd.col        = in_data[15:8];
        in_cmd.row        = in_data[23:16];
        in_cmd.shift_cols = in_data[31:24];
        in_cmd.shift_rows = in_data[39:32];
        case (in_type)
            REQ_PUT:     in_cmd.kind = CMD_PUT;
            REQ_SET_POS: in_cmd.kind = CMD_SET_POS;
            REQ_SCROLL:  in_cmd.kind = CMD_SCROLL;
            REQ_FILL:    in_cmd.kind = CMD_FILL;
            REQ_READ:    in_cmd.kind = CMD_READ;
            default:     in_cmd.kind = CMD_NOP;
        endcase
    end

    // queue handshake
    assign in_ready  = enable && (count_reg != 2'(QDEPTH));
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_no_overflow, count_reg == 2'(QDEPTH), !push, "push into full queue")
    `ASSERT_NEXT(a_push_counts, push && !pop && count_reg == 2'd0, count_reg == 2'd1, "lost push")

endmodule

`default_nettype wire

// ===== hdl/tcce_back.sv =====
// back end: cell store, cursor and the sequencer that carries out commands
// depends on tcce_pkg
`default_nettype none

module tcce_back
    import tcce_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    store_ready,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(DEPTH);
    localparam int MEM_W = 24;

    logic [MEM_W-1:0] mem [DEPTH];
    logic [MEM_W-1:0] mem_q;

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [6:0]        cur_col_reg;
    logic [6:0]        cur_row_reg;
    logic [7:0]        chr_reg;
    logic signed [9:0] x_reg, y_reg;
    logic signed [9:0] hz_reg, vt_reg;
    logic [7:0]        w_reg, h_reg;
    logic [7:0]        cw_reg, ch_reg;
    phase_t            phase_reg;
    logic [7:0]        i_reg, i_end_reg;
    logic [7:0]        j_reg, j_beg_reg, j_end_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              rd_ok_reg;
    logic              rd_res_reg;
    logic              res_valid_reg;
    result_t           res_reg;

    logic [7:0]        w_eff, h_eff;
    pos_t              pos;
    logic signed [9:0] wn, hn, hz_sat, vt_sat, ah_full, av_full;
    logic [7:0]        rx, ry;
    logic [9:0]        dst_col, dst_row;
    logic signed [10:0] src_col, src_row;
    logic [8:0]        mul_col, mul_row;
    logic [ADDR_W-1:0] addr_calc;
    logic              addr_ok;
    logic              nonempty;
    logic              last_cell;
    logic              ph_more;
    phase_t            ph_next;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_widx;
    logic [MEM_W-1:0]  mem_wdata;
    logic              res_free;
    result_t           res_new;

    // effective region and cursor placement
    assign w_eff = eff_width(cfg.region_width);
    assign h_eff = eff_height(cfg.region_height);
    assign pos   = place_cursor(x_reg, y_reg, w_eff, h_eff);

    // scroll amount saturation
    always_comb
    begin
        wn = $signed({2'b00, w_reg});
        hn = $signed({2'b00, h_reg});
        if (hz_reg > wn)       hz_sat = wn;
        else if (hz_reg < -wn) hz_sat = -wn;
        else                   hz_sat = hz_reg;
        if (vt_reg > hn)       vt_sat = hn;
        else if (vt_reg < -hn) vt_sat = -hn;
        else                   vt_sat = vt_reg;
        ah_full = hz_sat[9] ? -hz_sat : hz_sat;
        av_full = vt_sat[9] ? -vt_sat : vt_sat;
    end

    // walk coordinates, mirrored for negative column or row shifts
    always_comb
    begin
        rx = hz_reg[9] ? (w_reg - 8'd1 - j_reg) : j_reg;
        ry = vt_reg[9] ? (h_reg - 8'd1 - i_reg) : i_reg;
        dst_col = {3'b0, cfg.region_col} + {2'b0, rx};
        dst_row = {3'b0, cfg.region_row} + {2'b0, ry};
        src_col = $signed({1'b0, dst_col}) + $signed({hz_reg[9], hz_reg});
        src_row = $signed({1'b0, dst_row}) + $signed({vt_reg[9], vt_reg});
    end

    // address multiplier input select
    always_comb
    begin
        case (state_reg)
            ST_PUT_ADDR:
            begin
                mul_col = {2'b0, cfg.region_col} + {2'b0, cur_col_reg};
                mul_row = {2'b0, cfg.region_row} + {2'b0, cur_row_reg};
            end
            ST_RD_ADDR:
            begin
                mul_col = {1'b0, x_reg[7:0]};
                mul_row = {1'b0, y_reg[7:0]};
            end
            ST_LOOP_ADDR:
            begin
                if (phase_reg == PH_COPY)
                begin
                    mul_col = src_col[8:0];
                    mul_row = src_row[8:0];
                end
                else
                begin
                    mul_col = dst_col[8:0];
                    mul_row = dst_row[8:0];
                end
            end
            default:
            begin
                mul_col = dst_col[8:0];
                mul_row = dst_row[8:0];
            end
        endcase
    end

    assign addr_calc = cell_addr(mul_col, mul_row, cfg.row_pitch);
    assign addr_ok   = (addr_reg < DEPTH_A);

    // loop bookkeeping
    assign nonempty  = (i_reg < i_end_reg) && (j_beg_reg < j_end_reg);
    assign last_cell = (j_reg + 8'd1 == j_end_reg) && (i_reg + 8'd1 == i_end_reg);

    // phase order: copy, blank vacated columns, blank vacated rows
    always_comb
    begin
        ph_more = 1'b0;
        ph_next = PH_BLANK_V;
        case (phase_reg)
            PH_COPY:
            begin
                if (hz_reg != 10'sd0)
                begin
                    ph_more = 1'b1;
                    ph_next = PH_BLANK_H;
                end
                else if (vt_reg != 10'sd0)
                begin
                    ph_more = 1'b1;
                end
            end
            PH_BLANK_H: ph_more = (vt_reg != 10'sd0);
            default:    ph_more = 1'b0;
        endcase
    end

    assign res_free = !res_valid_reg || res_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == IDX_W'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_PUT:     state_next = ST_PUT_ADDR;
                        CMD_SET_POS: state_next = ST_SET_POS;
                        CMD_SCROLL:  state_next = ST_SCR_SETUP;
                        CMD_FILL:    state_next = ST_PHASE;
                        CMD_READ:
                            state_next = (cmd.col[7] || cmd.row[7]) ? ST_DONE : ST_RD_ADDR;
                        default:     state_next = ST_DONE;
                    endcase
                end
            ST_PUT_ADDR:  state_next = ST_PUT_WR;
            ST_PUT_WR:    state_next = ST_SET_POS;
            ST_SET_POS:   state_next = pos.scroll ? ST_SCR_SETUP : ST_DONE;
            ST_SCR_SETUP: state_next = ST_PHASE;
            ST_PHASE:
                if (nonempty)     state_next = ST_LOOP_ADDR;
                else if (!ph_more) state_next = ST_DONE;
            ST_LOOP_ADDR:
                state_next = (phase_reg == PH_COPY) ? ST_LOOP_RD : ST_LOOP_WR;
            ST_LOOP_RD:   state_next = ST_LOOP_WR;
            ST_LOOP_WR:   state_next = last_cell ? ST_PHASE : ST_LOOP_ADDR;
            ST_RD_ADDR:   state_next = ST_RD_MEM;
            ST_RD_MEM:    state_next = ST_DONE;
            ST_DONE:
                if (res_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_ready   = (state_reg == ST_IDLE);
        store_ready = (state_reg != ST_CLEAR);
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_widx    = addr_reg[IDX_W-1:0];
        mem_wdata   = {cfg.text_color, BLANK_CHAR};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_widx  = clr_cnt_reg;
                mem_wdata = {16'h0000, BLANK_CHAR};
            end
            ST_PUT_WR:
            begin
                mem_we    = addr_ok;
                mem_wdata = {cfg.text_color, chr_reg};
            end
            ST_LOOP_RD, ST_RD_MEM:
                mem_re = addr_ok;
            ST_LOOP_WR:
            begin
                mem_we = addr_ok;
                if (phase_reg == PH_COPY)
                    mem_wdata = rd_ok_reg ? mem_q : '0;
                else if (phase_reg == PH_FILL)
                    mem_wdata = {cfg.text_color, chr_reg};
            end
            default: ;
        endcase
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_widx] <= mem_wdata;
        if (mem_re) mem_q <= mem[addr_reg[IDX_W-1:0]];
    end

    // result word
    always_comb
    begin
        res_new.cursor_col     = cur_col_reg;
        res_new.cursor_row     = cur_row_reg;
        res_new.cursor_abs_col = {1'b0, cfg.region_col} + {1'b0, cur_col_reg};
        res_new.cursor_abs_row = {1'b0, cfg.region_row} + {1'b0, cur_row_reg};
        res_new.read_char      = (rd_res_reg && rd_ok_reg) ? mem_q[7:0] : 8'h00;
        res_new.read_color     = (rd_res_reg && rd_ok_reg) ? mem_q[23:8] : 16'h0000;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_col_reg   <= 7'd0;
            cur_row_reg   <= 7'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (state_reg == ST_SET_POS)
            begin
                cur_col_reg <= pos.col;
                cur_row_reg <= pos.row;
            end
            if (state_reg == ST_DONE && res_free) res_valid_reg <= 1'b1;
            else if (res_ready)                   res_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    chr_reg    <= cmd.chr;
                    x_reg      <= $signed({{2{cmd.col[7]}}, cmd.col});
                    y_reg      <= $signed({{2{cmd.row[7]}}, cmd.row});
                    hz_reg     <= (cmd.kind == CMD_FILL) ? 10'sd0
                                  : $signed({{2{cmd.shift_cols[7]}}, cmd.shift_cols});
                    vt_reg     <= (cmd.kind == CMD_FILL) ? 10'sd0
                                  : $signed({{2{cmd.shift_rows[7]}}, cmd.shift_rows});
                    w_reg      <= w_eff;
                    h_reg      <= h_eff;
                    rd_res_reg <= (cmd.kind == CMD_READ);
                    rd_ok_reg  <= 1'b0;
                    if (cmd.kind == CMD_FILL)
                    begin
                        phase_reg <= PH_FILL;
                        i_reg     <= 8'd0;
                        i_end_reg <= h_eff;
                        j_reg     <= 8'd0;
                        j_beg_reg <= 8'd0;
                        j_end_reg <= w_eff;
                    end
                end
            ST_PUT_ADDR, ST_RD_ADDR, ST_LOOP_ADDR:
                addr_reg <= addr_calc;
            ST_PUT_WR:
            begin
                x_reg <= $signed({3'b000, cur_col_reg}) + 10'sd1;
                y_reg <= $signed({3'b000, cur_row_reg});
            end
            ST_SET_POS:
            begin
                hz_reg <= '0;
                vt_reg <= pos.vt;
            end
            ST_SCR_SETUP:
            begin
                hz_reg    <= hz_sat;
                vt_reg    <= vt_sat;
                cw_reg    <= w_reg - ah_full[7:0];
                ch_reg    <= h_reg - av_full[7:0];
                phase_reg <= PH_COPY;
                i_reg     <= 8'd0;
                i_end_reg <= h_reg - av_full[7:0];
                j_reg     <= 8'd0;
                j_beg_reg <= 8'd0;
                j_end_reg <= w_reg - ah_full[7:0];
            end
            ST_PHASE:
                if (!nonempty && ph_more)
                begin
                    phase_reg <= ph_next;
                    if (ph_next == PH_BLANK_H)
                    begin
                        i_reg     <= 8'd0;
                        i_end_reg <= h_reg;
                        j_reg     <= cw_reg;
                        j_beg_reg <= cw_reg;
                        j_end_reg <= w_reg;
                    end
                    else
                    begin
                        i_reg     <= ch_reg;
                        i_end_reg <= h_reg;
                        j_reg     <= 8'd0;
                        j_beg_reg <= 8'd0;
                        j_end_reg <= w_reg;
                    end
                end
            ST_LOOP_RD:
            begin
                rd_ok_reg <= addr_ok;
                addr_reg  <= addr_calc;
            end
            ST_RD_MEM:
                rd_ok_reg <= addr_ok;
            ST_LOOP_WR:
                if (j_reg + 8'd1 == j_end_reg)
                begin
                    j_reg <= j_beg_reg;
                    i_reg <= i_reg + 8'd1;
                end
                else
                begin
                    j_reg <= j_reg + 8'd1;
                end
            ST_DONE:
                if (res_free) res_reg <= res_new;
            default: ;
        endcase
    end

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_one_access, mem_we, !mem_re, "store written and read in one cycle")
    `ASSERT_IMPLY(a_copy_order, state_reg == ST_LOOP_WR && phase_reg == PH_COPY,
        $past(state_reg) == ST_LOOP_RD, "copy write without a source read")
    `ASSERT_IMPLY(a_walk_bounds, state_reg == ST_LOOP_ADDR,
        i_reg < i_end_reg && j_reg < j_end_reg, "region walk out of bounds")

endmodule

`default_nettype wire

// ===== hdl/text_console_cell_engine.sv =====
// Text console cell engine: character and colour cell store with a cursor
// relative to a configurable region. After reset the store is swept to blank
// cells with s_tready low; configuration writes are taken throughout.
// Commands then run one at a time on the single write and single read port
// of the store. Scroll and fill walk the region: each copied cell takes an
// address, a read and a write step, and each blanked or filled cell an
// address and a write step. A set position or put that runs off the bottom
// of the region adds such a scroll. A two-entry command queue lets items
// arrive while a walk is under way, and a result waits in its own register
// until taken.
// depends on tcce_pkg, tcce_front and tcce_back
`default_nettype none

module text_console_cell_engine
    import tcce_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code, col, row, shift_cols, shift_rows
    input  logic [39:0] s_tdata,
    // req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_col, cursor_row, cursor_abs_col, cursor_abs_row, read_char, read_color
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    logic    store_ready;
    result_t res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_col    <= 7'd0;
            cfg_reg.region_row    <= 7'd0;
            cfg_reg.region_width  <= WIDTH_RESET;
            cfg_reg.region_height <= HEIGHT_RESET;
            cfg_reg.row_pitch     <= PITCH_RESET;
            cfg_reg.text_color    <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_COL:    cfg_reg.region_col    <= cfg_data[6:0];
                REG_REGION_ROW:    cfg_reg.region_row    <= cfg_data[6:0];
                REG_REGION_WIDTH:  cfg_reg.region_width  <= cfg_data[7:0];
                REG_REGION_HEIGHT: cfg_reg.region_height <= cfg_data[6:0];
                REG_ROW_PITCH:     cfg_reg.row_pitch     <= cfg_data[7:0];
                REG_TEXT_COLOR:    cfg_reg.text_color    <= cfg_data;
                default: ;
            endcase
        end
    end

    // command intake and queue
    tcce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (store_ready),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_data   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // command execution and store
    tcce_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .store_ready (store_ready),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {2'b00, res};

endmodule

`default_nettype wire
